@@ hdl/acte_pkg.sv @@
package acte_pkg;

	localparam int unsigned HourW  = 5;
	localparam int unsigned MinW   = 6;
	localparam int unsigned SecW   = 6;
	localparam int unsigned PulseW = 12;
	localparam int unsigned WordW  = 16;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 6;

	localparam logic [ByteW-1:0] ClearByte = 8'h72;

	localparam logic [HourW-1:0] LastHour   = 5'd23;
	localparam logic [MinW-1:0]  LastMinute = 6'd59;
	localparam logic [SecW-1:0]  LastSecond = 6'd59;

	localparam logic [HourW-1:0] HourReset        = 5'd12;
	localparam logic [MinW-1:0]  MinuteReset      = 6'd39;
	localparam logic [SecW-1:0]  SecondReset      = 6'd18;
	localparam logic [HourW-1:0] AlarmHourReset   = 5'd12;
	localparam logic [MinW-1:0]  AlarmMinuteReset = 6'd39;
	localparam logic [SecW-1:0]  AlarmSecondReset = 6'd35;

	localparam logic [PulseW-1:0] PulseMinUs = 12'd500;
	// Ceiling of 2^17/3 and of 2^18/9; exact over the value ranges used here.
	localparam logic [16:0] RecipThird = 17'd43691;
	localparam logic [14:0] RecipNinth = 15'd29128;

	localparam logic [WordW-1:0] SegAlarmA = 16'h00F7;
	localparam logic [WordW-1:0] SegAlarmL = 16'h0038;
	localparam logic [WordW-1:0] SegAlarmR = 16'h20F3;
	localparam logic [WordW-1:0] SegAlarmM = 16'h0536;

	typedef enum logic [CfgIdxW-1:0] {
		CfgAlarmHour   = 2'd0,
		CfgAlarmMinute = 2'd1,
		CfgAlarmSecond = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [HourW-1:0] hours;
		logic [MinW-1:0]  minutes;
		logic [SecW-1:0]  seconds;
	} clock_time_t;

	typedef struct packed {
		logic was_latched;
		logic fast;
		logic normal;
		logic latched_next;
	} alarm_status_t;

	function automatic logic [WordW-1:0] seg_digit(input logic [3:0] d);
		logic [WordW-1:0] w;
		case (d)
			4'd0: w = 16'h0C3F;
			4'd1: w = 16'h0006;
			4'd2: w = 16'h00DB;
			4'd3: w = 16'h008F;
			4'd4: w = 16'h00E6;
			4'd5: w = 16'h2069;
			4'd6: w = 16'h00FD;
			4'd7: w = 16'h0007;
			4'd8: w = 16'h00FF;
			4'd9: w = 16'h00EF;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] tens_of(input logic [MinW-1:0] v);
		logic [3:0] t;
		if (v >= 6'd50) t = 4'd5;
		else if (v >= 6'd40) t = 4'd4;
		else if (v >= 6'd30) t = 4'd3;
		else if (v >= 6'd20) t = 4'd2;
		else if (v >= 6'd10) t = 4'd1;
		else t = 4'd0;
		return t;
	endfunction

	function automatic logic [3:0] units_of(input logic [MinW-1:0] v);
		logic [MinW-1:0] r;
		r = v - MinW'(tens_of(v)) * 6'd10;
		return r[3:0];
	endfunction

endpackage

@@ hdl/acte_if.sv @@
interface acte_in_if
	import acte_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             rx_valid;
	logic [ByteW-1:0] rx_byte;

	modport source (output valid, output rx_valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_valid, input rx_byte, output ready);
endinterface

interface acte_out_if
	import acte_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [PulseW-1:0] second_pulse_us;
	logic [PulseW-1:0] minute_pulse_us;
	logic [WordW-1:0]  digit_word0;
	logic [WordW-1:0]  digit_word1;
	logic [WordW-1:0]  digit_word2;
	logic [WordW-1:0]  digit_word3;
	logic              alarm_on;
	logic              blink_fast_pulse;
	logic              blink_normal_pulse;

	modport source (
		output valid, output second_pulse_us, output minute_pulse_us,
		output digit_word0, output digit_word1, output digit_word2, output digit_word3,
		output alarm_on, output blink_fast_pulse, output blink_normal_pulse,
		input ready
	);
	modport sink (
		input valid, input second_pulse_us, input minute_pulse_us,
		input digit_word0, input digit_word1, input digit_word2, input digit_word3,
		input alarm_on, input blink_fast_pulse, input blink_normal_pulse,
		output ready
	);
endinterface

@@ hdl/acte_timekeep.sv @@
module acte_timekeep
	import acte_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          clear,
	input  clock_time_t   alarm_time,
	output clock_time_t   now,
	output alarm_status_t status
);

	clock_time_t time_q;
	clock_time_t time_next;
	logic        latched_q;
	logic        match;

	assign now   = time_q;
	assign match = (time_q == alarm_time);

	assign status.was_latched  = latched_q;
	assign status.fast         = match | latched_q;
	assign status.normal       = clear;
	assign status.latched_next = (match | latched_q) & ~clear;

	always_comb begin
		time_next = time_q;
		if (time_q.seconds == LastSecond) begin
			time_next.seconds = '0;
			if (time_q.minutes == LastMinute) begin
				time_next.minutes = '0;
				if (time_q.hours == LastHour) begin
					time_next.hours = '0;
				end else begin
					time_next.hours = time_q.hours + 1'b1;
				end
			end else begin
				time_next.minutes = time_q.minutes + 1'b1;
			end
		end else begin
			time_next.seconds = time_q.seconds + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q.hours   <= HourReset;
			time_q.minutes <= MinuteReset;
			time_q.seconds <= SecondReset;
			latched_q      <= 1'b0;
		end else if (advance) begin
			time_q    <= time_next;
			latched_q <= status.latched_next;
		end
	end

endmodule

@@ hdl/acte_pulse.sv @@
module acte_pulse
	import acte_pkg::*;
(
	input  clock_time_t       now,
	output logic [PulseW-1:0] second_pulse,
	output logic [PulseW-1:0] minute_pulse
);

	logic [12:0] sec_scaled;
	logic [29:0] sec_prod;
	logic [11:0] sec_in_hour;
	logic [14:0] hour_scaled;
	logic [29:0] min_prod;

	// 2000*s/60 is 100*s/3; 2000*x/3600 is 5*x/9.
	assign sec_scaled   = 13'(now.seconds) * 13'd100;
	assign sec_prod     = 30'(sec_scaled) * 30'(RecipThird);
	assign second_pulse = PulseMinUs + PulseW'(sec_prod[29:17]);

	assign sec_in_hour  = 12'(now.minutes) * 12'd60 + 12'(now.seconds);
	assign hour_scaled  = 15'(sec_in_hour) * 15'd5;
	assign min_prod     = 30'(hour_scaled) * 30'(RecipNinth);
	assign minute_pulse = PulseMinUs + PulseW'(min_prod[29:18]);

endmodule

@@ hdl/acte_display.sv @@
module acte_display
	import acte_pkg::*;
(
	input  clock_time_t      now,
	input  logic             alarm,
	output logic [WordW-1:0] word0,
	output logic [WordW-1:0] word1,
	output logic [WordW-1:0] word2,
	output logic [WordW-1:0] word3
);

	logic [MinW-1:0] hours_wide;

	assign hours_wide = MinW'(now.hours);

	always_comb begin
		if (alarm) begin
			word0 = SegAlarmA;
			word1 = SegAlarmL;
			word2 = SegAlarmR;
			word3 = SegAlarmM;
		end else begin
			word0 = seg_digit(tens_of(hours_wide));
			word1 = seg_digit(units_of(hours_wide));
			word2 = seg_digit(tens_of(now.minutes));
			word3 = seg_digit(units_of(now.minutes));
		end
	end

endmodule

@@ hdl/alarm_clock_tick_engine.sv @@
// One transfer on tick is one second of time, optionally with a received byte; each tick
// gives exactly one result transfer, computed from the time held before that tick. The block
// accepts one tick per cycle: all work is a single registered pass from the time and alarm
// registers to the result register, and a new tick is taken while the previous result is
// still waiting, provided the result side takes it in the same cycle. After reset the time is
// 12:39:18 and the alarm time 12:39:35. Alarm registers are written through cfg_we,
// cfg_index and cfg_data (hour, minute, second at indexes 0 to 2); the user must write them
// only while no tick is in flight, which the block does not enforce. An hour above 23 or a
// minute or second above 59 never matches. A received 'r' clears the alarm latch on its tick.
module alarm_clock_tick_engine
	import acte_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	acte_in_if.sink             tick,
	acte_out_if.source          result,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	clock_time_t       alarm_q;
	clock_time_t       now;
	alarm_status_t     status;
	logic              accept;
	logic              clear;
	logic [PulseW-1:0] second_pulse;
	logic [PulseW-1:0] minute_pulse;
	logic [WordW-1:0]  word0;
	logic [WordW-1:0]  word1;
	logic [WordW-1:0]  word2;
	logic [WordW-1:0]  word3;

	logic              out_valid_q;
	logic [PulseW-1:0] second_pulse_q;
	logic [PulseW-1:0] minute_pulse_q;
	logic [WordW-1:0]  word0_q;
	logic [WordW-1:0]  word1_q;
	logic [WordW-1:0]  word2_q;
	logic [WordW-1:0]  word3_q;
	logic              alarm_on_q;
	logic              fast_q;
	logic              normal_q;

	assign tick.ready = ~out_valid_q | result.ready;
	assign accept     = tick.valid & tick.ready;
	assign clear      = tick.rx_valid & (tick.rx_byte == ClearByte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q.hours   <= AlarmHourReset;
			alarm_q.minutes <= AlarmMinuteReset;
			alarm_q.seconds <= AlarmSecondReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgAlarmHour:   alarm_q.hours   <= cfg_data[HourW-1:0];
				CfgAlarmMinute: alarm_q.minutes <= cfg_data[MinW-1:0];
				CfgAlarmSecond: alarm_q.seconds <= cfg_data[SecW-1:0];
				default: ;
			endcase
		end
	end

	acte_timekeep u_timekeep (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.clear      (clear),
		.alarm_time (alarm_q),
		.now        (now),
		.status     (status)
	);

	acte_pulse u_pulse (
		.now          (now),
		.second_pulse (second_pulse),
		.minute_pulse (minute_pulse)
	);

	acte_display u_display (
		.now   (now),
		.alarm (status.was_latched),
		.word0 (word0),
		.word1 (word1),
		.word2 (word2),
		.word3 (word3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			second_pulse_q <= second_pulse;
			minute_pulse_q <= minute_pulse;
			word0_q        <= word0;
			word1_q        <= word1;
			word2_q        <= word2;
			word3_q        <= word3;
			alarm_on_q     <= status.latched_next;
			fast_q         <= status.fast;
			normal_q       <= status.normal;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.second_pulse_us    = second_pulse_q;
	assign result.minute_pulse_us    = minute_pulse_q;
	assign result.digit_word0        = word0_q;
	assign result.digit_word1        = word1_q;
	assign result.digit_word2        = word2_q;
	assign result.digit_word3        = word3_q;
	assign result.alarm_on           = alarm_on_q;
	assign result.blink_fast_pulse   = fast_q;
	assign result.blink_normal_pulse = normal_q;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("accepted tick produced no result");

	a_clear_drops_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && clear) |=> (!result.alarm_on && result.blink_normal_pulse))
		else $error("clear byte did not clear the alarm");

	a_latch_implies_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.alarm_on) |-> result.blink_fast_pulse)
		else $error("alarm latched without fast blink");

	a_empty_is_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> tick.ready)
		else $error("tick stalled with empty result register");

endmodule
